// ===== design/stt_pkg.sv =====
// shared types, token kind codes, keyword table and byte class helpers
// for the source text tokenizer; no dependencies
package stt_pkg;

    localparam int STT_POS_BITS     = 32;
    localparam int STT_LEN_BITS     = 16;
    localparam int STT_KW_MAX_CHARS = 9;
    localparam int KW_CHARS         = 9;
    localparam int KW_COUNT         = 35;
    localparam int RES_SLOTS        = 3;
    localparam int RES_DEPTH        = 4;

    typedef logic [6:0] kind_t;

    localparam kind_t K_INT      = 7'd0;
    localparam kind_t K_FLOAT    = 7'd1;
    localparam kind_t K_STRING   = 7'd2;
    localparam kind_t K_CHAR     = 7'd3;
    localparam kind_t K_DOUBLE   = 7'd4;
    localparam kind_t K_ADD      = 7'd36;
    localparam kind_t K_SUB      = 7'd37;
    localparam kind_t K_STAR     = 7'd38;
    localparam kind_t K_DIV      = 7'd39;
    localparam kind_t K_EQ       = 7'd40;
    localparam kind_t K_NEQ      = 7'd41;
    localparam kind_t K_LT       = 7'd42;
    localparam kind_t K_GT       = 7'd43;
    localparam kind_t K_LEQ      = 7'd44;
    localparam kind_t K_GEQ      = 7'd45;
    localparam kind_t K_MOD      = 7'd49;
    localparam kind_t K_INC      = 7'd50;
    localparam kind_t K_DEC      = 7'd51;
    localparam kind_t K_EXP      = 7'd52;
    localparam kind_t K_ASSIGN   = 7'd53;
    localparam kind_t K_ADD_EQ   = 7'd54;
    localparam kind_t K_SUB_EQ   = 7'd55;
    localparam kind_t K_MUL_EQ   = 7'd56;
    localparam kind_t K_DIV_EQ   = 7'd57;
    localparam kind_t K_EXP_EQ   = 7'd58;
    localparam kind_t K_MOD_EQ   = 7'd59;
    localparam kind_t K_COMMA    = 7'd60;
    localparam kind_t K_SEMI     = 7'd61;
    localparam kind_t K_LPAREN   = 7'd62;
    localparam kind_t K_RPAREN   = 7'd63;
    localparam kind_t K_LBRACE   = 7'd64;
    localparam kind_t K_RBRACE   = 7'd65;
    localparam kind_t K_LBRACKET = 7'd66;
    localparam kind_t K_RBRACKET = 7'd67;
    localparam kind_t K_IDENT    = 7'd68;
    localparam kind_t K_ARROW    = 7'd70;
    localparam kind_t K_END      = 7'd71;
    localparam kind_t K_CONTENT  = 7'd72;
    localparam kind_t K_ERROR    = 7'd73;
    localparam kind_t K_NONE     = 7'd127;

    localparam logic [7:0] CH_END_MARK = 8'hFF;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_TAB      = 8'h09;

    typedef enum logic [3:0] {
        M_IDLE,
        M_OP,
        M_COMMENT,
        M_STR,
        M_STR_ESC,
        M_CHR_OPEN,
        M_CHR_ESC,
        M_CHR_CLOSE,
        M_NUM_INT,
        M_NUM_FRAC,
        M_WORD
    } scan_mode_t;

    typedef enum logic [2:0] {
        E_NONE,
        E_UNKNOWN,
        E_OPEN_STRING,
        E_OPEN_CHAR,
        E_EMPTY_CHAR,
        E_LONE_BANG
    } err_code_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] value;
        err_code_t  err;
        logic       last;
    } tok_meta_t;

    // words are right justified: char i sits at bits [8*(len-1-i) +: 8]
    typedef struct packed {
        logic [8*KW_CHARS-1:0] word;
        logic [3:0]            len;
        kind_t                 kind;
    } kw_entry_t;

    localparam kw_entry_t KW_TABLE [KW_COUNT] = '{
        '{"true", 4'd4, 7'd10},     '{"false", 4'd5, 7'd11},
        '{"int", 4'd3, 7'd29},      '{"double", 4'd6, 7'd31},
        '{"char", 4'd4, 7'd32},     '{"float", 4'd5, 7'd30},
        '{"string", 4'd6, 7'd33},   '{"void", 4'd4, 7'd34},
        '{"bool", 4'd4, 7'd35},     '{"sniff", 4'd5, 7'd5},
        '{"whimper", 4'd7, 7'd6},   '{"seek", 4'd4, 7'd20},
        '{"hunt", 4'd4, 7'd7},      '{"chase", 4'd5, 7'd8},
        '{"bark", 4'd4, 7'd9},      '{"cub", 4'd3, 7'd12},
        '{"plunge", 4'd6, 7'd13},   '{"fox", 4'd3, 7'd14},
        '{"burrow", 4'd6, 7'd15},   '{"inherit", 4'd7, 7'd16},
        '{"growl", 4'd5, 7'd17},    '{"show", 4'd4, 7'd18},
        '{"kitsune", 4'd7, 7'd19},  '{"den", 4'd3, 7'd21},
        '{"fluff", 4'd5, 7'd22},    '{"territory", 4'd9, 7'd23},
        '{"pack", 4'd4, 7'd24},     '{"guarded", 4'd7, 7'd25},
        '{"vanish", 4'd6, 7'd69},   '{"and", 4'd3, 7'd46},
        '{"or", 4'd2, 7'd47},       '{"not", 4'd3, 7'd48},
        '{"stop", 4'd4, 7'd26},     '{"pounce", 4'd6, 7'd27},
        '{"forage", 4'd6, 7'd28}
    };

    function automatic logic is_space(input logic [7:0] c);
        return (c == " ") || (c inside {[8'h09:8'h0D]});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {["0":"9"]};
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return c inside {["a":"z"], ["A":"Z"]};
    endfunction

    function automatic logic [7:0] esc_byte(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c == "n")
            r = CH_LF;
        else if (c == "t")
            r = CH_TAB;
        return r;
    endfunction

    function automatic kind_t single_op(input logic [7:0] op);
        kind_t k;
        case (op)
            "+":     k = K_ADD;
            "-":     k = K_SUB;
            "=":     k = K_ASSIGN;
            "^":     k = K_EXP;
            "*":     k = K_STAR;
            "%":     k = K_MOD;
            "/":     k = K_DIV;
            "<":     k = K_LT;
            ">":     k = K_GT;
            default: k = K_NONE;
        endcase
        return k;
    endfunction

    function automatic kind_t pair_op(input logic [7:0] op, input logic [7:0] c);
        kind_t k;
        k = K_NONE;
        if (c == "=")
        begin
            case (op)
                "+":     k = K_ADD_EQ;
                "-":     k = K_SUB_EQ;
                "=":     k = K_EQ;
                "^":     k = K_EXP_EQ;
                "*":     k = K_MUL_EQ;
                "%":     k = K_MOD_EQ;
                "/":     k = K_DIV_EQ;
                "<":     k = K_LEQ;
                ">":     k = K_GEQ;
                "!":     k = K_NEQ;
                default: k = K_NONE;
            endcase
        end
        else if (op == "+" && c == "+")
            k = K_INC;
        else if (op == "-" && c == "-")
            k = K_DEC;
        else if (op == "-" && c == ">")
            k = K_ARROW;
        return k;
    endfunction

    function automatic kind_t punct_kind(input logic [7:0] c);
        kind_t k;
        case (c)
            ",":     k = K_COMMA;
            ";":     k = K_SEMI;
            "(":     k = K_LPAREN;
            ")":     k = K_RPAREN;
            "{":     k = K_LBRACE;
            "}":     k = K_RBRACE;
            "[":     k = K_LBRACKET;
            "]":     k = K_RBRACKET;
            default: k = K_NONE;
        endcase
        return k;
    endfunction

    function automatic tok_meta_t mk_meta(input kind_t k, input logic [7:0] v,
                                          input err_code_t e);
        tok_meta_t m;
        m.kind  = k;
        m.value = v;
        m.err   = e;
        m.last  = 1'b0;
        return m;
    endfunction

endpackage

// ===== design/stt_if.sv =====
// handshake channels of the tokenizer: source bytes in, tokens out
// depends on stt_pkg
interface stt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       end_of_text;

    modport source (output valid, char_byte, end_of_text, input ready);
    modport sink   (input valid, char_byte, end_of_text, output ready);
endinterface

interface stt_token_if #(
    parameter int POS_BITS = stt_pkg::STT_POS_BITS,
    parameter int LEN_BITS = stt_pkg::STT_LEN_BITS
);
    logic                valid;
    logic                ready;
    logic [6:0]          token_kind;
    logic [POS_BITS-1:0] start_pos;
    logic [LEN_BITS-1:0] token_len;
    logic [7:0]          value_byte;
    logic [2:0]          error_code;
    logic                last;

    modport source (output valid, token_kind, start_pos, token_len, value_byte,
                    error_code, last, input ready);
    modport sink   (input valid, token_kind, start_pos, token_len, value_byte,
                    error_code, last, output ready);
endinterface

// ===== design/stt_kw_match.sv =====
// parallel match of the current word against the keyword table
// depends on stt_pkg
module stt_kw_match #(
    parameter int KEYWORD_MAX_CHARS = stt_pkg::STT_KW_MAX_CHARS,
    parameter int LEN_BITS          = stt_pkg::STT_LEN_BITS
) (
    input  logic [7:0]          chars [KEYWORD_MAX_CHARS],
    input  logic [LEN_BITS-1:0] len,
    output stt_pkg::kind_t      kind
);
    import stt_pkg::*;

    always_comb
    begin
        logic hit;
        kind = K_IDENT;
        for (int e = KW_COUNT - 1; e >= 0; e--)
        begin
            hit = (len == LEN_BITS'(KW_TABLE[e].len));
            for (int i = 0; i < KW_CHARS; i++)
            begin
                if (i < int'(KW_TABLE[e].len))
                begin
                    if (chars[i] != KW_TABLE[e].word[8*(int'(KW_TABLE[e].len)-1-i) +: 8])
                        hit = 1'b0;
                end
            end
            if (hit)
                kind = KW_TABLE[e].kind;
        end
    end

endmodule

// ===== design/stt_scan.sv =====
// scanner state and the per-byte step: next state plus up to three results
// depends on stt_pkg and stt_kw_match
module stt_scan #(
    parameter int POS_BITS          = stt_pkg::STT_POS_BITS,
    parameter int KEYWORD_MAX_CHARS = stt_pkg::STT_KW_MAX_CHARS,
    parameter int LEN_BITS          = stt_pkg::STT_LEN_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      step,
    input  logic [7:0]                char_byte,
    input  logic                      end_of_text,
    output logic [1:0]                res_cnt,
    output stt_pkg::tok_meta_t        res_meta [stt_pkg::RES_SLOTS],
    output logic [POS_BITS-1:0]       res_pos  [stt_pkg::RES_SLOTS],
    output logic [LEN_BITS-1:0]       res_len  [stt_pkg::RES_SLOTS]
);
    import stt_pkg::*;

    localparam logic [LEN_BITS-1:0] LEN_ONE = LEN_BITS'(1);
    localparam logic [LEN_BITS-1:0] LEN_TWO = LEN_BITS'(2);

    scan_mode_t          mode_reg, mode_next;
    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic [POS_BITS-1:0] start_reg, start_next;
    logic [LEN_BITS-1:0] wlen_reg, wlen_next;
    logic [7:0]          held_reg, held_next;
    logic                halted_reg, halted_next;
    logic [7:0]          wbuf_reg  [KEYWORD_MAX_CHARS];
    logic [7:0]          wbuf_view [KEYWORD_MAX_CHARS];

    logic [LEN_BITS-1:0] wl_inc;
    logic [LEN_BITS-1:0] kw_len;
    kind_t               kw_kind;
    logic                alnum;
    logic                again;
    logic                ended;

    logic                slot_v    [4];
    tok_meta_t           slot_meta [4];
    logic [POS_BITS-1:0] slot_pos  [4];
    logic [LEN_BITS-1:0] slot_len  [4];

    assign wl_inc = (&wlen_reg) ? wlen_reg : wlen_reg + LEN_ONE;
    assign alnum  = is_alpha(char_byte) || is_digit(char_byte);

    // word as it stands after this byte; a new word always starts at entry 0
    always_comb
    begin
        for (int i = 0; i < KEYWORD_MAX_CHARS; i++)
        begin
            wbuf_view[i] = wbuf_reg[i];
            if (mode_reg != M_WORD)
            begin
                if (i == 0)
                    wbuf_view[i] = char_byte;
            end
            else if (alnum && wlen_reg == LEN_BITS'(i))
                wbuf_view[i] = char_byte;
        end
    end

    // length the keyword lookup sees: ending word, continued word or new word
    always_comb
    begin
        if (mode_reg == M_WORD)
            kw_len = alnum ? wl_inc : wlen_reg;
        else
            kw_len = LEN_ONE;
    end

    stt_kw_match #(
        .KEYWORD_MAX_CHARS (KEYWORD_MAX_CHARS),
        .LEN_BITS          (LEN_BITS)
    ) u_kw (
        .chars (wbuf_view),
        .len   (kw_len),
        .kind  (kw_kind)
    );

    // next state for one byte
    always_comb
    begin
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        start_next  = start_reg;
        wlen_next   = wlen_reg;
        held_next   = held_reg;
        halted_next = halted_reg;
        again       = 1'b0;
        ended       = 1'b0;
        for (int s = 0; s < 4; s++)
        begin
            slot_v[s]    = 1'b0;
            slot_meta[s] = mk_meta(K_NONE, 8'h00, E_NONE);
            slot_pos[s]  = start_reg;
            slot_len[s]  = '0;
        end

        if (!halted_reg)
        begin
            // byte inside the current token
            case (mode_reg)
                M_OP:
                begin
                    if (pair_op(held_reg, char_byte) != K_NONE)
                    begin
                        slot_v[0]    = 1'b1;
                        slot_meta[0] = mk_meta(pair_op(held_reg, char_byte), 8'h00, E_NONE);
                        slot_len[0]  = LEN_TWO;
                        mode_next    = M_IDLE;
                    end
                    else if (held_reg == "/" && char_byte == "/")
                        mode_next = M_COMMENT;
                    else
                    begin
                        slot_v[0]   = 1'b1;
                        slot_len[0] = LEN_ONE;
                        if (single_op(held_reg) == K_NONE)
                            slot_meta[0] = mk_meta(K_ERROR, 8'h00, E_LONE_BANG);
                        else
                            slot_meta[0] = mk_meta(single_op(held_reg), 8'h00, E_NONE);
                        mode_next = M_IDLE;
                        again     = 1'b1;
                    end
                end
                M_COMMENT:
                begin
                    if (char_byte == CH_LF)
                        mode_next = M_IDLE;
                end
                M_STR:
                begin
                    if (char_byte == "\"")
                    begin
                        slot_v[0]    = 1'b1;
                        slot_meta[0] = mk_meta(K_STRING, 8'h00, E_NONE);
                        slot_len[0]  = wl_inc;
                        mode_next    = M_IDLE;
                    end
                    else
                    begin
                        if (char_byte == "\\")
                            mode_next = M_STR_ESC;
                        else
                        begin
                            slot_v[0]    = 1'b1;
                            slot_meta[0] = mk_meta(K_CONTENT, char_byte, E_NONE);
                            slot_pos[0]  = pos_reg;
                            slot_len[0]  = LEN_ONE;
                        end
                        wlen_next = wl_inc;
                    end
                end
                M_STR_ESC:
                begin
                    slot_v[0]    = 1'b1;
                    slot_meta[0] = mk_meta(K_CONTENT, esc_byte(char_byte), E_NONE);
                    slot_pos[0]  = pos_reg - 1'b1;
                    slot_len[0]  = LEN_TWO;
                    wlen_next    = wl_inc;
                    mode_next    = M_STR;
                end
                M_CHR_OPEN:
                begin
                    wlen_next = wl_inc;
                    if (char_byte == "\\")
                        mode_next = M_CHR_ESC;
                    else if (char_byte == "'")
                    begin
                        slot_v[0]    = 1'b1;
                        slot_meta[0] = mk_meta(K_ERROR, 8'h00, E_EMPTY_CHAR);
                        slot_len[0]  = wl_inc;
                        halted_next  = 1'b1;
                        mode_next    = M_IDLE;
                    end
                    else
                    begin
                        held_next = char_byte;
                        mode_next = M_CHR_CLOSE;
                    end
                end
                M_CHR_ESC:
                begin
                    wlen_next = wl_inc;
                    held_next = esc_byte(char_byte);
                    mode_next = M_CHR_CLOSE;
                end
                M_CHR_CLOSE:
                begin
                    wlen_next   = wl_inc;
                    slot_v[0]   = 1'b1;
                    slot_len[0] = wl_inc;
                    mode_next   = M_IDLE;
                    if (char_byte == "'")
                        slot_meta[0] = mk_meta(K_CHAR, held_reg, E_NONE);
                    else
                    begin
                        slot_meta[0] = mk_meta(K_ERROR, 8'h00, E_OPEN_CHAR);
                        halted_next  = 1'b1;
                    end
                end
                M_NUM_INT, M_NUM_FRAC:
                begin
                    if (is_digit(char_byte))
                        wlen_next = wl_inc;
                    else if (char_byte == "." && mode_reg == M_NUM_INT)
                    begin
                        wlen_next = wl_inc;
                        mode_next = M_NUM_FRAC;
                    end
                    else if (char_byte == "f")
                    begin
                        slot_v[0]    = 1'b1;
                        slot_meta[0] = mk_meta(K_FLOAT, 8'h00, E_NONE);
                        slot_len[0]  = wl_inc;
                        mode_next    = M_IDLE;
                    end
                    else
                    begin
                        slot_v[0]    = 1'b1;
                        slot_meta[0] = mk_meta((mode_reg == M_NUM_INT) ? K_INT : K_DOUBLE,
                                               8'h00, E_NONE);
                        slot_len[0]  = wlen_reg;
                        mode_next    = M_IDLE;
                        again        = 1'b1;
                    end
                end
                M_WORD:
                begin
                    if (alnum)
                        wlen_next = wl_inc;
                    else
                    begin
                        slot_v[0]    = 1'b1;
                        slot_meta[0] = mk_meta(kw_kind, 8'h00, E_NONE);
                        slot_len[0]  = wlen_reg;
                        mode_next    = M_IDLE;
                        again        = 1'b1;
                    end
                end
                default:
                begin
                    mode_next = M_IDLE;
                    again     = 1'b1;
                end
            endcase

            // byte opens a new token
            if (again && !halted_next)
            begin
                start_next = pos_reg;
                wlen_next  = LEN_ONE;
                if (!is_space(char_byte))
                begin
                    if (char_byte == CH_END_MARK)
                        ended = 1'b1;
                    else if (single_op(char_byte) != K_NONE || char_byte == "!")
                    begin
                        held_next = char_byte;
                        mode_next = M_OP;
                    end
                    else if (char_byte == "\"")
                        mode_next = M_STR;
                    else if (char_byte == "'")
                        mode_next = M_CHR_OPEN;
                    else if (is_digit(char_byte))
                        mode_next = M_NUM_INT;
                    else if (is_alpha(char_byte))
                        mode_next = M_WORD;
                    else
                    begin
                        slot_v[1]   = 1'b1;
                        slot_pos[1] = pos_reg;
                        slot_len[1] = LEN_ONE;
                        if (punct_kind(char_byte) != K_NONE)
                            slot_meta[1] = mk_meta(punct_kind(char_byte), 8'h00, E_NONE);
                        else
                        begin
                            slot_meta[1] = mk_meta(K_ERROR, 8'h00, E_UNKNOWN);
                            halted_next  = 1'b1;
                            mode_next    = M_IDLE;
                        end
                    end
                end
            end

            // flush of a pending token at the end of the text, then the end token
            if (!halted_next)
            begin
                pos_next = pos_reg + 1'b1;
                if (!ended && end_of_text)
                begin
                    slot_pos[2] = start_next;
                    slot_len[2] = wlen_next;
                    case (mode_next)
                        M_OP:
                        begin
                            slot_v[2]   = 1'b1;
                            slot_len[2] = LEN_ONE;
                            if (single_op(held_next) == K_NONE)
                                slot_meta[2] = mk_meta(K_ERROR, 8'h00, E_LONE_BANG);
                            else
                                slot_meta[2] = mk_meta(single_op(held_next), 8'h00, E_NONE);
                        end
                        M_WORD:
                        begin
                            slot_v[2]    = 1'b1;
                            slot_meta[2] = mk_meta(kw_kind, 8'h00, E_NONE);
                        end
                        M_NUM_INT:
                        begin
                            slot_v[2]    = 1'b1;
                            slot_meta[2] = mk_meta(K_INT, 8'h00, E_NONE);
                        end
                        M_NUM_FRAC:
                        begin
                            slot_v[2]    = 1'b1;
                            slot_meta[2] = mk_meta(K_DOUBLE, 8'h00, E_NONE);
                        end
                        M_STR, M_STR_ESC:
                        begin
                            slot_v[2]    = 1'b1;
                            slot_meta[2] = mk_meta(K_ERROR, 8'h00, E_OPEN_STRING);
                            halted_next  = 1'b1;
                            mode_next    = M_IDLE;
                        end
                        M_CHR_OPEN, M_CHR_ESC, M_CHR_CLOSE:
                        begin
                            slot_v[2]    = 1'b1;
                            slot_meta[2] = mk_meta(K_ERROR, 8'h00, E_OPEN_CHAR);
                            halted_next  = 1'b1;
                            mode_next    = M_IDLE;
                        end
                        default:
                        begin
                            slot_v[2] = 1'b0;
                        end
                    endcase
                    if (!halted_next)
                        ended = 1'b1;
                end
                if (ended)
                begin
                    slot_v[3]    = 1'b1;
                    slot_meta[3] = mk_meta(K_END, 8'h00, E_NONE);
                    slot_pos[3]  = pos_reg + 1'b1;
                    slot_len[3]  = '0;
                    mode_next    = M_IDLE;
                    pos_next     = '0;
                    start_next   = '0;
                    wlen_next    = '0;
                end
            end
        end
    end

    // pack the live slots in order and flag the final one
    always_comb
    begin
        logic [2:0] n;
        n = 3'd0;
        for (int k = 0; k < RES_SLOTS; k++)
        begin
            res_meta[k] = mk_meta(K_NONE, 8'h00, E_NONE);
            res_pos[k]  = '0;
            res_len[k]  = '0;
        end
        for (int s = 0; s < 4; s++)
        begin
            if (slot_v[s] && n < 3'(RES_SLOTS))
            begin
                res_meta[n[1:0]] = slot_meta[s];
                res_pos[n[1:0]]  = slot_pos[s];
                res_len[n[1:0]]  = slot_len[s];
                n = n + 3'd1;
            end
        end
        for (int k = 0; k < RES_SLOTS; k++)
            res_meta[k].last = (3'(k) + 3'd1 == n);
        res_cnt = n[1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_IDLE;
            pos_reg    <= '0;
            start_reg  <= '0;
            wlen_reg   <= '0;
            held_reg   <= '0;
            halted_reg <= 1'b0;
        end
        else if (step)
        begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            start_reg  <= start_next;
            wlen_reg   <= wlen_next;
            held_reg   <= held_next;
            halted_reg <= halted_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && !halted_reg)
        begin
            for (int i = 0; i < KEYWORD_MAX_CHARS; i++)
                wbuf_reg[i] <= wbuf_view[i];
        end
    end

endmodule

// ===== design/stt_res_fifo.sv =====
// result queue: takes up to three results per cycle, hands out one per transaction
// depends on stt_pkg
module stt_res_fifo #(
    parameter int POS_BITS = stt_pkg::STT_POS_BITS,
    parameter int LEN_BITS = stt_pkg::STT_LEN_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [1:0]          push_cnt,
    input  stt_pkg::tok_meta_t  push_meta [stt_pkg::RES_SLOTS],
    input  logic [POS_BITS-1:0] push_pos  [stt_pkg::RES_SLOTS],
    input  logic [LEN_BITS-1:0] push_len  [stt_pkg::RES_SLOTS],
    output logic [2:0]          free,
    output logic                out_valid,
    input  logic                out_ready,
    output stt_pkg::tok_meta_t  out_meta,
    output logic [POS_BITS-1:0] out_pos,
    output logic [LEN_BITS-1:0] out_len
);
    import stt_pkg::*;

    tok_meta_t           meta_mem [RES_DEPTH];
    logic [POS_BITS-1:0] pos_mem  [RES_DEPTH];
    logic [LEN_BITS-1:0] len_mem  [RES_DEPTH];

    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic [1:0] n_in;
    logic       pop;

    assign n_in        = push ? push_cnt : 2'd0;
    assign pop         = out_valid && out_ready;
    assign wr_ptr_next = wr_ptr_reg + n_in;
    assign rd_ptr_next = rd_ptr_reg + {1'b0, pop};
    assign count_next  = count_reg + {1'b0, n_in} - {2'b00, pop};
    assign free        = 3'(RES_DEPTH) - count_reg;

    assign out_valid = (count_reg != 3'd0);
    assign out_meta  = meta_mem[rd_ptr_reg];
    assign out_pos   = pos_mem[rd_ptr_reg];
    assign out_len   = len_mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < RES_SLOTS; k++)
        begin
            if (2'(k) < n_in)
            begin
                meta_mem[wr_ptr_reg + 2'(k)] <= push_meta[k];
                pos_mem[wr_ptr_reg + 2'(k)]  <= push_pos[k];
                len_mem[wr_ptr_reg + 2'(k)]  <= push_len[k];
            end
        end
    end

endmodule

// ===== design/source_text_tokenizer.sv =====
// source_text_tokenizer: one source byte per transaction in, tokens out.
// a byte waits in the input register until the scanner takes it, and its results
// are shown on the token channel from the result queue. throughput: one byte
// per cycle while each byte yields at most one result and tokens are taken; the
// queue drains at most one token per cycle, so bytes with 2-3 results can stall.
// reset: asynchronous, clears scanner mode, position, error halt and the queues.
module source_text_tokenizer #(
    parameter int POS_BITS          = stt_pkg::STT_POS_BITS,
    parameter int KEYWORD_MAX_CHARS = stt_pkg::STT_KW_MAX_CHARS,
    parameter int LEN_BITS          = stt_pkg::STT_LEN_BITS
) (
    input logic   clk,
    input logic   rst_n,
    stt_byte_if.sink    src,
    stt_token_if.source tok
);
    import stt_pkg::*;

    // input register: holds one byte until the scanner can place all its results
    logic       in_full_reg;
    logic [7:0] in_char_reg;
    logic       in_eot_reg;

    logic                res_cnt_w;
    logic [1:0]          res_cnt;
    tok_meta_t           res_meta [RES_SLOTS];
    logic [POS_BITS-1:0] res_pos  [RES_SLOTS];
    logic [LEN_BITS-1:0] res_len  [RES_SLOTS];
    logic [2:0]          free;
    logic                fire;
    tok_meta_t           out_meta;

    // the byte is scanned once the queue has room for every result it causes
    assign res_cnt_w = ({1'b0, res_cnt} <= free);
    assign fire      = in_full_reg && res_cnt_w;

    // a new byte is taken when none is held or the held one leaves in the same cycle
    assign src.ready = !in_full_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_full_reg <= 1'b0;
        else if (src.ready)
            in_full_reg <= src.valid;
    end

    // payload capture needs no reset
    always_ff @(posedge clk)
    begin
        if (src.valid && src.ready)
        begin
            in_char_reg <= src.char_byte;
            in_eot_reg  <= src.end_of_text;
        end
    end

    // scanner: token state machine, keyword lookup and per-byte results
    stt_scan #(
        .POS_BITS          (POS_BITS),
        .KEYWORD_MAX_CHARS (KEYWORD_MAX_CHARS),
        .LEN_BITS          (LEN_BITS)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (fire),
        .char_byte   (in_char_reg),
        .end_of_text (in_eot_reg),
        .res_cnt     (res_cnt),
        .res_meta    (res_meta),
        .res_pos     (res_pos),
        .res_len     (res_len)
    );

    // result queue: separates the scanner from backpressure on the token side
    stt_res_fifo #(
        .POS_BITS (POS_BITS),
        .LEN_BITS (LEN_BITS)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fire),
        .push_cnt  (res_cnt),
        .push_meta (res_meta),
        .push_pos  (res_pos),
        .push_len  (res_len),
        .free      (free),
        .out_valid (tok.valid),
        .out_ready (tok.ready),
        .out_meta  (out_meta),
        .out_pos   (tok.start_pos),
        .out_len   (tok.token_len)
    );

    assign tok.token_kind = out_meta.kind;
    assign tok.value_byte = out_meta.value;
    assign tok.error_code = out_meta.err;
    assign tok.last       = out_meta.last;

endmodule

// ===== design/stt_checker.sv =====
// port level checks on the token channel of the tokenizer, bound to the top level
// depends on stt_pkg and source_text_tokenizer
module stt_checker #(
    parameter int POS_BITS = stt_pkg::STT_POS_BITS,
    parameter int LEN_BITS = stt_pkg::STT_LEN_BITS
) (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input logic [6:0]          token_kind,
    input logic [POS_BITS-1:0] start_pos,
    input logic [LEN_BITS-1:0] token_len,
    input logic [7:0]          value_byte,
    input logic [2:0]          error_code,
    input logic                last
);
    import stt_pkg::*;

    // a stalled transaction keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(token_kind)
            && $stable(start_pos) && $stable(token_len) && $stable(value_byte))
        else $error("token payload changed under backpressure");

    // an error code travels only with an error token
    a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((token_kind == K_ERROR) == (error_code != 3'd0)))
        else $error("error code and token kind disagree");

    // the end token is empty and closes its byte
    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind == K_END |-> token_len == '0 && last)
        else $error("malformed end token");

    // string content spans one byte or an escape pair
    a_content: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind == K_CONTENT |->
            token_len == LEN_BITS'(1) || token_len == LEN_BITS'(2))
        else $error("content item with bad length");

    // nothing follows a halting error until reset
    a_halt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && token_kind == K_ERROR && error_code != E_LONE_BANG
            |=> !out_valid)
        else $error("token after a halting error");

endmodule

bind source_text_tokenizer stt_checker #(
    .POS_BITS (POS_BITS),
    .LEN_BITS (LEN_BITS)
) u_stt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (tok.valid),
    .out_ready  (tok.ready),
    .token_kind (tok.token_kind),
    .start_pos  (tok.start_pos),
    .token_len  (tok.token_len),
    .value_byte (tok.value_byte),
    .error_code (tok.error_code),
    .last       (tok.last)
);
